@@ sv/ucea_pkg.sv @@
`default_nettype none

package ucea_pkg;

	// default upper limit on tries per series
	localparam int MAX_TRIES_DEF = 16;

	// field widths fixed by the interface
	localparam int TICK_W = 16;
	localparam int TREQ_W = 8;

	// trigger length after reset
	localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 16'd20;

	// saturation value of the echo width counter
	localparam logic [TICK_W-1:0] WIDTH_MAX = 16'hFFFF;

	// measurement phase of the tick sequencer
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_HIGH
	} phase_t;

	// handshake sequencer state
	typedef enum logic {
		CTL_RUN,
		CTL_DIV
	} ctl_state_t;

	// per-tick status from the tick sequencer
	typedef struct packed {
		logic trigger;
		logic busy;
		logic done;
	} tick_res_t;

endpackage

`default_nettype wire

@@ sv/ucea_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module ucea_div #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// one compare-and-subtract step
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ sv/ucea_tick.sv @@
`default_nettype none

// per-tick measurement sequencer: trigger, echo wait, echo width count, sum
module ucea_tick #(
	parameter int MAX_TRIES = ucea_pkg::MAX_TRIES_DEF,
	parameter int TRY_W     = $clog2(MAX_TRIES + 1),
	parameter int SUM_W     = ucea_pkg::TICK_W + TRY_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        start_req,
	input  wire logic [ucea_pkg::TREQ_W-1:0] tries_req,
	input  wire logic                        echo_level,
	input  wire logic [ucea_pkg::TICK_W-1:0] trigger_ticks,
	output ucea_pkg::tick_res_t              res,
	output logic [SUM_W-1:0]                 sum_total,
	output logic [TRY_W-1:0]                 tries_total
);

	ucea_pkg::phase_t              phase_q, phase_d;
	logic [ucea_pkg::TICK_W-1:0]   trig_cnt_q, trig_cnt_d;
	logic [ucea_pkg::TICK_W-1:0]   width_q, width_d;
	logic [SUM_W-1:0]              sum_q, sum_d;
	logic [TRY_W-1:0]              total_q, total_d;
	logic [TRY_W-1:0]              tdone_q, tdone_d;
	logic [ucea_pkg::TICK_W-1:0]   tlen;
	logic [ucea_pkg::TREQ_W-1:0]   treq_c;

	// zero trigger length acts as one
	assign tlen = (trigger_ticks == '0) ? ucea_pkg::TICK_W'(1) : trigger_ticks;

	// clamp requested tries into range
	always_comb begin
		if (tries_req == '0) begin
			treq_c = ucea_pkg::TREQ_W'(1);
		end else if (tries_req > ucea_pkg::TREQ_W'(MAX_TRIES)) begin
			treq_c = ucea_pkg::TREQ_W'(MAX_TRIES);
		end else begin
			treq_c = tries_req;
		end
	end

	// next state and tick status
	always_comb begin
		phase_d    = phase_q;
		trig_cnt_d = trig_cnt_q;
		width_d    = width_q;
		sum_d      = sum_q;
		total_d    = total_q;
		tdone_d    = tdone_q;
		res        = '0;
		unique case (phase_q)
			ucea_pkg::PH_IDLE: begin
				if (start_req) begin
					total_d    = TRY_W'(treq_c);
					tdone_d    = '0;
					sum_d      = '0;
					width_d    = '0;
					trig_cnt_d = '0;
					phase_d    = ucea_pkg::PH_TRIG;
				end
			end
			ucea_pkg::PH_TRIG: begin
				res.trigger = 1'b1;
				trig_cnt_d  = trig_cnt_q + ucea_pkg::TICK_W'(1);
				if (trig_cnt_d >= tlen) begin
					phase_d = ucea_pkg::PH_WAIT;
				end
			end
			ucea_pkg::PH_WAIT: begin
				if (echo_level) begin
					width_d = ucea_pkg::TICK_W'(1);
					phase_d = ucea_pkg::PH_HIGH;
				end
			end
			ucea_pkg::PH_HIGH: begin
				if (echo_level) begin
					if (width_q != ucea_pkg::WIDTH_MAX) begin
						width_d = width_q + ucea_pkg::TICK_W'(1);
					end
				end else begin
					// falling echo closes this try
					sum_d   = sum_q + SUM_W'(width_q);
					tdone_d = tdone_q + TRY_W'(1);
					width_d = '0;
					if (tdone_d >= total_q) begin
						res.done = 1'b1;
						phase_d  = ucea_pkg::PH_IDLE;
					end else begin
						trig_cnt_d = '0;
						phase_d    = ucea_pkg::PH_TRIG;
					end
				end
			end
			default: begin
				phase_d = ucea_pkg::PH_IDLE;
			end
		endcase
		res.busy = (phase_d != ucea_pkg::PH_IDLE);
	end

	// state registers advance once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ucea_pkg::PH_IDLE;
			trig_cnt_q <= '0;
			width_q    <= '0;
			sum_q      <= '0;
			total_q    <= TRY_W'(1);
			tdone_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			trig_cnt_q <= trig_cnt_d;
			width_q    <= width_d;
			sum_q      <= sum_d;
			total_q    <= total_d;
			tdone_q    <= tdone_d;
		end
	end

	assign sum_total   = sum_d;
	assign tries_total = total_q;

endmodule

`default_nettype wire

@@ sv/ultrasonic_echo_averager.sv @@
`default_nettype none

// Ultrasonic ranging echo timer. Each request on the input channel is one
// microsecond tick carrying a start flag, a try count and the sampled echo
// level; each tick gives exactly one result with the trigger level, busy,
// done and the averaged echo width. A start while idle clamps the try count
// to 1..MAX_TRIES, then every try drives the trigger for trigger_ticks ticks
// (0 acts as 1), waits for echo high and counts echo-high ticks (saturating
// at 65535). After the last try the truncated mean is reported with done.
// An ordinary tick is taken and its result is registered, and a new tick
// is taken while the previous result is being read out unless the output
// is stalled. The tick that ends a series goes through a serial restoring
// divider producing one quotient bit per cycle, with the input stalled
// until its result appears. trigger_ticks may be written only while no
// tick is in flight.
module ultrasonic_echo_averager #(
	parameter int MAX_TRIES = ucea_pkg::MAX_TRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [ucea_pkg::TICK_W-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        start_req,
	input  wire logic [ucea_pkg::TREQ_W-1:0] tries_req,
	input  wire logic                        echo_level,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             trigger_out,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [ucea_pkg::TICK_W-1:0]      average_ticks
);

	localparam int TRY_W = $clog2(MAX_TRIES + 1);
	localparam int SUM_W = ucea_pkg::TICK_W + TRY_W;

	ucea_pkg::ctl_state_t          state_q, state_d;
	logic [ucea_pkg::TICK_W-1:0]   trig_ticks_q;
	logic                          out_valid_q, out_valid_d;
	logic                          trig_q, busy_q, done_q;
	logic [ucea_pkg::TICK_W-1:0]   avg_q;
	logic                          accept;
	logic                          div_start;
	logic                          div_done;
	logic [SUM_W-1:0]              quotient;
	ucea_pkg::tick_res_t           res;
	logic [SUM_W-1:0]              sum_total;
	logic [TRY_W-1:0]              tries_total;

	// trigger length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= ucea_pkg::TRIGGER_TICKS_RST;
		end else if (cfg_wr_en) begin
			trig_ticks_q <= cfg_wr_data;
		end
	end

	ucea_tick #(
		.MAX_TRIES (MAX_TRIES),
		.TRY_W     (TRY_W),
		.SUM_W     (SUM_W)
	) u_tick (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.start_req     (start_req),
		.tries_req     (tries_req),
		.echo_level    (echo_level),
		.trigger_ticks (trig_ticks_q),
		.res           (res),
		.sum_total     (sum_total),
		.tries_total   (tries_total)
	);

	ucea_div #(
		.NUM_W (SUM_W),
		.DEN_W (TRY_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_total),
		.divisor  (tries_total),
		.done     (div_done),
		.quotient (quotient)
	);

	// handshake sequencer: next state and strobes
	always_comb begin
		state_d     = state_q;
		in_stall    = (state_q == ucea_pkg::CTL_DIV) || (out_valid_q && out_stall);
		accept      = in_valid && !in_stall;
		div_start   = accept && res.done;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ucea_pkg::CTL_RUN: begin
				if (div_start) begin
					state_d = ucea_pkg::CTL_DIV;
				end else if (accept) begin
					out_valid_d = 1'b1;
				end
			end
			ucea_pkg::CTL_DIV: begin
				if (div_done) begin
					out_valid_d = 1'b1;
					state_d     = ucea_pkg::CTL_RUN;
				end
			end
			default: begin
				state_d = ucea_pkg::CTL_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ucea_pkg::CTL_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			trig_q <= res.trigger;
			busy_q <= res.busy;
			done_q <= res.done;
			avg_q  <= '0;
		end else if (div_done) begin
			avg_q <= quotient[ucea_pkg::TICK_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_out   = trig_q;
	assign busy_res      = busy_q;
	assign done_res      = done_q;
	assign average_ticks = avg_q;

endmodule

`default_nettype wire

@@ sv/ucea_chk.sv @@
`default_nettype none

module ucea_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        trigger_out,
	input wire logic        busy_res,
	input wire logic        done_res,
	input wire logic [15:0] average_ticks
);

	// done ends the series: not busy, no trigger
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !trigger_out)
		else $error("done result while busy or triggering");

	// average is zero outside the done result
	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> average_ticks == 16'd0)
		else $error("nonzero average without done");

	// trigger only during a series
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_out |-> busy_res)
		else $error("trigger without busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(average_ticks)
			&& $stable(done_res))
		else $error("stalled result changed");

endmodule

bind ultrasonic_echo_averager ucea_chk u_chk (.*);

`default_nettype wire
